@@ hdl/led_mode_effect_refresher_defines.svh @@
// ----------------------------------------------------------------------------
// LED refresher assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_MODE_EFFECT_REFRESHER_DEFINES_SVH
`define LED_MODE_EFFECT_REFRESHER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LMER_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lmer: property violated");

// condition must never be seen outside reset
`define LMER_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lmer: forbidden condition");

`else

`define LMER_ASSERT(lbl, clk, rst, prop)
`define LMER_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ hdl/lmer_pkg.sv @@
// ----------------------------------------------------------------------------
// lmer_pkg
// Widths, codes and constants shared by the LED refresher files.
// ----------------------------------------------------------------------------
package lmer_pkg;

  // string geometry
  localparam int LED_COUNT   = 5;
  localparam int COLOR_COUNT = 9;

  // field widths
  localparam int REQ_TYPE_W  = 2;
  localparam int LED_NUM_W   = 3;
  localparam int COLOR_W     = 4;
  localparam int REQ_MODE_W  = 3;
  localparam int LEVEL_REQ_W = 8;
  localparam int TIME_W      = 32;
  localparam int LED_IDX_W   = 3;
  localparam int BRIGHT_W    = 4;
  localparam int REL_W       = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int REFRESH_W   = 8;
  localparam int TEST_IVL_W  = 16;
  localparam int DIVISOR_W   = 11;
  localparam int TRI_W       = 10;
  localparam int SCALED_W    = TRI_W + REL_W;

  // shared divide-by-125 unit: 2000 = 16 * 125, 1000 = 8 * 125
  localparam int PHASE_LSB_W = 4;
  localparam int SCALE_LSB_W = 3;
  localparam int DIV_IN_W    = TIME_W - PHASE_LSB_W;
  localparam int DIV_R_W     = 7;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 35;
  localparam int DIV_Q_W     = DIV_IN_W + RECIP_W - RECIP_SHIFT;
  // ceil(2^35 / 125), exact for every dividend below 2^28
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;

  // request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_TICK      = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_SET_MODE  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_SET_LEVEL = 2'd2;

  // LED modes
  localparam logic [MODE_W-1:0] MODE_ON     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BREATH = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_IVL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_IVL    = 2'd2;

  // register reset values
  localparam logic [REFRESH_W-1:0]  REFRESH_IVL_RST = 8'd20;
  localparam logic [TEST_IVL_W-1:0] TEST_IVL_RST    = 16'd500;

  // levels and colors
  localparam logic [BRIGHT_W-1:0] MAX_LEVEL    = 4'd10;
  localparam logic [BRIGHT_W-1:0] LEVEL_RST    = 4'd5;
  localparam logic [COLOR_W-1:0]  TEST_COLOR   = 4'd7;
  localparam logic [REL_W-1:0]    LEVEL_FULL   = 8'd255;
  localparam logic [REL_W-1:0]    LEVEL_NONE   = 8'd0;

  // animation timing in ms
  localparam logic [DIVISOR_W-1:0] BREATH_PERIOD = 11'd2000;
  localparam logic [DIVISOR_W-1:0] BREATH_HALF   = 11'd1000;
  localparam logic [DIVISOR_W-1:0] BLINK_SLOT    = 11'd500;
  localparam logic [DIVISOR_W-1:0] BLINK_SLOT3   = 11'd1500;

  // LED number / index limits
  localparam logic [LED_NUM_W-1:0] LED_NUM_MAX = LED_NUM_W'(LED_COUNT);
  localparam logic [LED_IDX_W-1:0] LAST_IDX    = LED_IDX_W'(LED_COUNT - 1);
  localparam logic [COLOR_W:0]     COLOR_LIMIT = (COLOR_W + 1)'(COLOR_COUNT);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/lmer_if.sv @@
// ----------------------------------------------------------------------------
// lmer channel interfaces
// Request, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: one beat per command or tick
interface lmer_req_if;
  logic                                valid;
  logic                                ready;
  logic [lmer_pkg::REQ_TYPE_W-1:0]     req_type;
  logic [lmer_pkg::LED_NUM_W-1:0]      led_number;
  logic [lmer_pkg::COLOR_W-1:0]        color_index;
  logic [lmer_pkg::REQ_MODE_W-1:0]     led_mode;
  logic [lmer_pkg::LEVEL_REQ_W-1:0]    level_request;
  logic [lmer_pkg::TIME_W-1:0]         now_ms;

  modport source (output valid, req_type, led_number, color_index, led_mode,
                  level_request, now_ms, input ready);
  modport sink   (input valid, req_type, led_number, color_index, led_mode,
                  level_request, now_ms, output ready);
endinterface

// result channel: one beat per LED of a refresh
interface lmer_res_if;
  logic                              valid;
  logic                              ready;
  logic [lmer_pkg::LED_IDX_W-1:0]    led_index;
  logic [lmer_pkg::COLOR_W-1:0]      color_out;
  logic [lmer_pkg::BRIGHT_W-1:0]     brightness_out;
  logic [lmer_pkg::REL_W-1:0]        relative_level;
  logic                              last_led;

  modport source (output valid, led_index, color_out, brightness_out,
                  relative_level, last_led, input ready);
  modport sink   (input valid, led_index, color_out, brightness_out,
                  relative_level, last_led, output ready);
endinterface

// register write channel
interface lmer_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lmer_pkg::CFG_IDX_W-1:0]     index;
  logic [lmer_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/led_mode_effect_refresher.sv @@
// ----------------------------------------------------------------------------
// led_mode_effect_refresher
// Per-LED color/mode store with brightness, test rotation and refresh
// sequencing for a string of five LEDs.
// ----------------------------------------------------------------------------
// Set-mode and brightness beats are taken in the idle state, which the block
// stays in. A tick that does not refresh goes through accept, test step and
// refresh decision, then back to idle. A tick that refreshes goes through
// accept, test step, refresh decision, then two passes through the shared
// divide-by-125 unit (time mod 2000 for the animation phase, then the breath
// scale by 1000) before its first result beat. It then emits one result beat
// per LED, five beats, paced by the result ready.
// Requests are not taken until the last beat of a refresh has gone out.
// Register writes are always taken and are meant for idle periods only.
`include "led_mode_effect_refresher_defines.svh"

module led_mode_effect_refresher (
  input  logic        clk,
  input  logic        rst,
  lmer_req_if.sink    req,
  lmer_res_if.source  res,
  lmer_cfg_if.sink    cfg
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TEST   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_PHASE  = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;

  // LED state
  logic [lmer_pkg::COLOR_W-1:0]    led_color [lmer_pkg::LED_COUNT];
  logic [lmer_pkg::MODE_W-1:0]     led_mode  [lmer_pkg::LED_COUNT];
  logic [lmer_pkg::BRIGHT_W-1:0]   brightness;
  logic                            dirty;
  logic [lmer_pkg::TIME_W-1:0]     last_refresh;
  logic [lmer_pkg::TIME_W-1:0]     last_test;
  logic [lmer_pkg::LED_IDX_W-1:0]  test_pos;
  logic                            test_started;

  // registers
  logic [lmer_pkg::REFRESH_W-1:0]  refresh_ivl;
  logic                            test_en;
  logic [lmer_pkg::TEST_IVL_W-1:0] test_ivl;

  // tick context
  logic [lmer_pkg::TIME_W-1:0]     now_q;
  logic                            blink_on;
  logic [lmer_pkg::REL_W-1:0]      breath_level;
  logic [lmer_pkg::LED_IDX_W-1:0]  emit_idx;

  // combinational helpers
  logic                            req_fire;
  logic                            res_fire;
  logic                            set_ok;
  logic [lmer_pkg::LED_IDX_W-1:0]  set_idx;
  logic [lmer_pkg::BRIGHT_W-1:0]   level_sat;
  logic                            test_due;
  logic                            animated;
  logic                            refresh_due;
  logic [lmer_pkg::DIVISOR_W-1:0]  phase;
  logic [lmer_pkg::TRI_W-1:0]      tri_x;
  logic [lmer_pkg::SCALED_W-1:0]   tri_scaled;
  logic                            blink_next;
  logic                            div_start;
  logic [lmer_pkg::DIV_IN_W-1:0]   div_dividend;
  logic [lmer_pkg::DIV_Q_W-1:0]    div_quo;
  logic [lmer_pkg::DIV_R_W-1:0]    div_rem;
  lmer_pkg::div_stat_t             div_stat;
  logic [lmer_pkg::MODE_W-1:0]     emit_mode;

  assign req_fire  = req.valid && req.ready;
  assign res_fire  = res.valid && res.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  // request decode
  always_comb begin
    set_ok = (req.led_number != '0) && (req.led_number <= lmer_pkg::LED_NUM_MAX)
          && ({1'b0, req.color_index} < lmer_pkg::COLOR_LIMIT)
          && (req.led_mode <= {1'b0, lmer_pkg::MODE_BREATH});
    set_idx   = lmer_pkg::LED_IDX_W'(req.led_number - 1'b1);
    level_sat = (req.level_request > {4'b0, lmer_pkg::MAX_LEVEL})
              ? lmer_pkg::MAX_LEVEL : req.level_request[lmer_pkg::BRIGHT_W-1:0];
  end

  // tick decisions
  always_comb begin
    animated = 1'b0;
    for (int i = 0; i < lmer_pkg::LED_COUNT; i++) begin
      if (led_mode[i] == lmer_pkg::MODE_BLINK || led_mode[i] == lmer_pkg::MODE_BREATH)
        animated = 1'b1;
    end
    test_due = test_en && (!test_started
             || ((now_q - last_test) >= lmer_pkg::TIME_W'(test_ivl)));
    refresh_due = dirty || (animated
                && ((now_q - last_refresh) >= lmer_pkg::TIME_W'(refresh_ivl)));
  end

  // animation phase: (time / 16) mod 125, low four time bits put back
  always_comb begin
    phase = {div_rem, now_q[lmer_pkg::PHASE_LSB_W-1:0]};
    if (phase < lmer_pkg::BREATH_HALF)
      tri_x = phase[lmer_pkg::TRI_W-1:0];
    else
      tri_x = lmer_pkg::TRI_W'(lmer_pkg::BREATH_PERIOD - phase);
    // x * 255 as (x << 8) - x
    tri_scaled = {tri_x, {lmer_pkg::REL_W{1'b0}}} - lmer_pkg::SCALED_W'(tri_x);
    blink_next = ((phase >= lmer_pkg::BLINK_SLOT) && (phase < lmer_pkg::BREATH_HALF))
              || (phase >= lmer_pkg::BLINK_SLOT3);
  end

  // shared divider operand select: time / 16, then scaled triangle / 8
  always_comb begin
    div_start = ((state == ST_DECIDE) && refresh_due)
             || ((state == ST_PHASE) && div_stat.done);
    if (state == ST_PHASE) begin
      div_dividend = lmer_pkg::DIV_IN_W'(
                       tri_scaled[lmer_pkg::SCALED_W-1:lmer_pkg::SCALE_LSB_W]);
    end else begin
      div_dividend = now_q[lmer_pkg::TIME_W-1:lmer_pkg::PHASE_LSB_W];
    end
  end

  lmer_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_ivl <= lmer_pkg::REFRESH_IVL_RST;
      test_en     <= 1'b1;
      test_ivl    <= lmer_pkg::TEST_IVL_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lmer_pkg::CFG_REFRESH_IVL: refresh_ivl <= cfg.data[lmer_pkg::REFRESH_W-1:0];
        lmer_pkg::CFG_TEST_EN:     test_en     <= cfg.data[0];
        lmer_pkg::CFG_TEST_IVL:    test_ivl    <= cfg.data[lmer_pkg::TEST_IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and LED state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      for (int i = 0; i < lmer_pkg::LED_COUNT; i++) begin
        led_color[i] <= '0;
        led_mode[i]  <= lmer_pkg::MODE_OFF;
      end
      brightness   <= lmer_pkg::LEVEL_RST;
      dirty        <= 1'b1;
      last_refresh <= '0;
      last_test    <= '0;
      test_pos     <= '0;
      test_started <= 1'b0;
      emit_idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            now_q <= req.now_ms;
            priority if (req.req_type == lmer_pkg::REQ_TICK) begin
              state <= ST_TEST;
            end else if (req.req_type == lmer_pkg::REQ_SET_MODE) begin
              if (set_ok) begin
                led_color[set_idx] <= req.color_index;
                led_mode[set_idx]  <= req.led_mode[lmer_pkg::MODE_W-1:0];
                dirty              <= 1'b1;
              end
            end else if (req.req_type == lmer_pkg::REQ_SET_LEVEL) begin
              brightness <= level_sat;
              dirty      <= 1'b1;
            end else begin
              // unknown request: dropped
            end
          end
        end
        ST_TEST: begin
          // rotate the single lit test LED
          if (test_due) begin
            for (int i = 0; i < lmer_pkg::LED_COUNT; i++) begin
              led_color[i] <= lmer_pkg::TEST_COLOR;
              led_mode[i]  <= (lmer_pkg::LED_IDX_W'(i) == test_pos)
                            ? lmer_pkg::MODE_ON : lmer_pkg::MODE_OFF;
            end
            brightness   <= lmer_pkg::MAX_LEVEL;
            dirty        <= 1'b1;
            test_pos     <= (test_pos == lmer_pkg::LAST_IDX) ? '0 : test_pos + 1'b1;
            last_test    <= now_q;
            test_started <= 1'b1;
          end
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (refresh_due) begin
            dirty        <= 1'b0;
            last_refresh <= now_q;
            state        <= ST_PHASE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PHASE: begin
          // phase ready: keep blink slot, start breath scaling
          if (div_stat.done) begin
            blink_on <= blink_next;
            state    <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (div_stat.done) begin
            breath_level <= div_quo[lmer_pkg::REL_W-1:0];
            emit_idx     <= '0;
            state        <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_fire) begin
            if (emit_idx == lmer_pkg::LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result beat, held stable until it is taken
  assign emit_mode = led_mode[emit_idx];

  always_comb begin
    res.valid          = (state == ST_EMIT);
    res.led_index      = emit_idx;
    res.color_out      = led_color[emit_idx];
    res.brightness_out = brightness;
    res.last_led       = (emit_idx == lmer_pkg::LAST_IDX);
    unique case (emit_mode)
      lmer_pkg::MODE_ON:    res.relative_level = lmer_pkg::LEVEL_FULL;
      lmer_pkg::MODE_OFF:   res.relative_level = lmer_pkg::LEVEL_NONE;
      lmer_pkg::MODE_BLINK: res.relative_level = blink_on ? lmer_pkg::LEVEL_FULL
                                                          : lmer_pkg::LEVEL_NONE;
      default:              res.relative_level = breath_level;
    endcase
  end

  // checks
  `LMER_NEVER(a_no_req_while_emit, clk, rst, res.valid && req.ready)
  `LMER_ASSERT(a_beat_advances, clk, rst, (res_fire && !res.last_led) |=> (res.valid && (res.led_index == $past(res.led_index) + 3'd1)))
  `LMER_NEVER(a_div_only_in_refresh, clk, rst, div_stat.busy && (state != ST_PHASE) && (state != ST_SCALE))
  `LMER_NEVER(a_level_in_range, clk, rst, brightness > lmer_pkg::MAX_LEVEL)

endmodule

@@ hdl/lmer_div.sv @@
// ----------------------------------------------------------------------------
// lmer_div
// Shared divide-by-125 unit. Multiplies by a fixed reciprocal, then gets the
// remainder by back-multiplication. Both are registered; done pulses once.
// ----------------------------------------------------------------------------
module lmer_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lmer_pkg::DIV_IN_W-1:0]     dividend,
  output logic [lmer_pkg::DIV_Q_W-1:0]      quotient,
  output logic [lmer_pkg::DIV_R_W-1:0]      remainder,
  output lmer_pkg::div_stat_t               stat
);

  localparam int PROD_W = lmer_pkg::DIV_IN_W + lmer_pkg::RECIP_W;

  logic [PROD_W-1:0]              prod;
  logic [lmer_pkg::DIV_IN_W-1:0]  num_q;
  logic                           busy;
  logic                           done;

  logic [lmer_pkg::DIV_Q_W-1:0]   quo_est;
  logic [lmer_pkg::DIV_IN_W-1:0]  quo_x125;
  logic [lmer_pkg::DIV_IN_W-1:0]  rem_full;

  // quotient from the product top bits, remainder as x - 125 * q
  always_comb begin
    quo_est  = prod[PROD_W-1:lmer_pkg::RECIP_SHIFT];
    quo_x125 = lmer_pkg::DIV_IN_W'({quo_est, 7'b0})
             - lmer_pkg::DIV_IN_W'({quo_est, 1'b0})
             - lmer_pkg::DIV_IN_W'(quo_est);
    rem_full = num_q - quo_x125;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // datapath: product on start, quotient and remainder registered while busy
  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= PROD_W'(dividend) * PROD_W'(lmer_pkg::RECIP_125);
      num_q <= dividend;
    end
    if (busy) begin
      quotient  <= quo_est;
      remainder <= rem_full[lmer_pkg::DIV_R_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
